FILE: sv/yokoi_connectivity_stream_core_assert.svh
`ifndef YOKOI_CONNECTIVITY_STREAM_CORE_ASSERT_SVH
`define YOKOI_CONNECTIVITY_STREAM_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define YCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define YCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/ycs_pkg.sv
package ycs_pkg;

	localparam int IMAGE_WIDTH  = 64;
	localparam int IMAGE_HEIGHT = 64;

	localparam int COL_W   = $clog2(IMAGE_WIDTH);
	localparam int ROW_W   = $clog2(IMAGE_HEIGHT + 1);
	localparam int GRAY_W  = 8;
	localparam int IDX_W   = 6;
	localparam int YOKOI_W = 3;

	localparam logic [COL_W-1:0]   LAST_COL        = COL_W'(IMAGE_WIDTH - 1);
	localparam logic [ROW_W-1:0]   LAST_ROW        = ROW_W'(IMAGE_HEIGHT - 1);
	localparam logic [ROW_W-1:0]   ROW_END         = ROW_W'(IMAGE_HEIGHT);
	localparam logic [GRAY_W-1:0]  THRESHOLD_RESET = GRAY_W'(128);
	localparam logic [YOKOI_W-1:0] INTERIOR_CODE   = YOKOI_W'(5);

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// one window column: [2] row above, [1] center row, [0] row below
	typedef logic [2:0] col_t;

	typedef struct packed {
		logic             pend1;
		logic             pend2;
		col_t             left;
		col_t             mid;
		col_t             right;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} job_t;

	function automatic logic [YOKOI_W-1:0] yokoi_calc(input col_t left, input col_t mid,
		input col_t right);
		logic [3:0]         a;
		logic [3:0]         d;
		logic [3:0]         e;
		logic [3:0]         r_hit;
		logic [3:0]         q_hit;
		logic [YOKOI_W-1:0] q_cnt;
		logic [YOKOI_W-1:0] res;
		a = {mid[0], left[1], mid[2], right[1]};
		d = {right[0], left[0], left[2], right[2]};
		e = {right[1], mid[0], left[1], mid[2]};
		r_hit = a & d & e;
		q_hit = a & ~(d & e);
		q_cnt = YOKOI_W'(q_hit[0]) + YOKOI_W'(q_hit[1]) + YOKOI_W'(q_hit[2])
			+ YOKOI_W'(q_hit[3]);
		priority if (!mid[1]) begin
			res = '0;
		end else if (&r_hit) begin
			res = INTERIOR_CODE;
		end else begin
			res = q_cnt;
		end
		return res;
	endfunction

endpackage

FILE: sv/ycs_front.sv
module ycs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_accept,
	input  logic                       kind,
	input  logic [ycs_pkg::GRAY_W-1:0] gray_pixel,
	input  logic [ycs_pkg::GRAY_W-1:0] threshold,
	output ycs_pkg::job_t              job
);
	import ycs_pkg::*;

	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [COL_W-1:0]       drain_col_q;
	logic [IMAGE_WIDTH-1:0] line1_q;
	logic [IMAGE_WIDTH-1:0] line2_q;
	col_t                   win1_q;
	col_t                   win2_q;

	logic is_pix;
	logic is_drain;
	logic fg;
	logic top_bit;
	col_t pix_col;
	col_t drain_mid;
	col_t drain_right;

	always_comb begin
		is_pix      = (kind == KIND_PIXEL) && (row_q < ROW_END);
		is_drain    = (kind == KIND_DRAIN) && (row_q == ROW_END);
		fg          = gray_pixel >= threshold;
		top_bit     = (row_q >= ROW_W'(2)) ? line2_q[0] : 1'b0;
		pix_col     = {top_bit, line1_q[0], fg};
		drain_mid   = {line2_q[0], line1_q[0], 1'b0};
		drain_right = (drain_col_q != LAST_COL) ? {line2_q[1], line1_q[1], 1'b0} : '0;
	end

	always_comb begin
		job = '0;
		priority if (is_pix) begin
			job.pend1 = (row_q != '0) && (col_q != '0);
			job.pend2 = (row_q != '0) && (col_q == LAST_COL);
			job.left  = (col_q >= COL_W'(2)) ? win2_q : '0;
			job.mid   = win1_q;
			job.right = pix_col;
			job.row   = row_q - ROW_W'(1);
			job.col   = col_q - COL_W'(1);
		end else if (is_drain) begin
			job.pend1 = 1'b1;
			job.left  = (drain_col_q != '0) ? win1_q : '0;
			job.mid   = drain_mid;
			job.right = drain_right;
			job.row   = LAST_ROW;
			job.col   = drain_col_q;
			job.last  = drain_col_q == LAST_COL;
		end else begin
			job = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			drain_col_q <= '0;
		end else if (in_accept && is_pix) begin
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (in_accept && is_drain) begin
			if (drain_col_q == LAST_COL) begin
				drain_col_q <= '0;
				row_q       <= '0;
				col_q       <= '0;
			end else begin
				drain_col_q <= drain_col_q + COL_W'(1);
			end
		end
	end

	// shift lines and window columns
	always_ff @(posedge clk) begin
		if (in_accept && is_pix) begin
			line1_q <= {fg, line1_q[IMAGE_WIDTH-1:1]};
			line2_q <= {line1_q[0], line2_q[IMAGE_WIDTH-1:1]};
			win2_q  <= win1_q;
			win1_q  <= pix_col;
		end else if (in_accept && is_drain) begin
			line1_q <= {1'b0, line1_q[IMAGE_WIDTH-1:1]};
			line2_q <= {line1_q[0], line2_q[IMAGE_WIDTH-1:1]};
			win1_q  <= drain_mid;
		end
	end

endmodule

FILE: sv/ycs_emit.sv
module ycs_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  ycs_pkg::job_t               job,
	output logic                        in_stall,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ycs_pkg::YOKOI_W-1:0] yokoi_number,
	output logic [ycs_pkg::IDX_W-1:0]   row_index,
	output logic [ycs_pkg::IDX_W-1:0]   column_index,
	output logic                        last_of_image
);
	import ycs_pkg::*;

	logic             pend1_s1;
	logic             pend2_s1;
	job_t             job_s1;
	logic             out_valid_q;
	logic [YOKOI_W-1:0] yokoi_q;
	logic [IDX_W-1:0] row_idx_q;
	logic [IDX_W-1:0] col_idx_q;
	logic             last_q;

	logic             load;
	col_t             sel_left;
	col_t             sel_mid;
	col_t             sel_right;
	logic [COL_W-1:0] sel_col;

	always_comb begin
		load     = (pend1_s1 || pend2_s1) && (!out_valid_q || !out_stall);
		in_stall = (pend1_s1 && pend2_s1) || ((pend1_s1 || pend2_s1) && !load);
		if (pend1_s1) begin
			sel_left  = job_s1.left;
			sel_mid   = job_s1.mid;
			sel_right = job_s1.right;
			sel_col   = job_s1.col;
		end else begin
			sel_left  = job_s1.mid;
			sel_mid   = job_s1.right;
			sel_right = '0;
			sel_col   = job_s1.col + COL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend1_s1    <= 1'b0;
			pend2_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				pend1_s1 <= job.pend1;
				pend2_s1 <= job.pend2;
			end else if (load) begin
				if (pend1_s1) begin
					pend1_s1 <= 1'b0;
				end else begin
					pend2_s1 <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			job_s1 <= job;
		end
		if (load) begin
			yokoi_q   <= yokoi_calc(sel_left, sel_mid, sel_right);
			row_idx_q <= IDX_W'(job_s1.row);
			col_idx_q <= IDX_W'(sel_col);
			last_q    <= pend1_s1 && job_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign yokoi_number  = yokoi_q;
	assign row_index     = row_idx_q;
	assign column_index  = col_idx_q;
	assign last_of_image = last_q;

endmodule

FILE: sv/yokoi_connectivity_stream_core.sv
// 4-connected Yokoi number of a binarized raster image, streamed.
// Input channel (in_valid/in_stall): kind 0 carries the next gray pixel in
// raster order; kind 1 is a drain tick that releases one result of the final
// row once the whole image has arrived. Ignored items are still taken.
// Output channel (out_valid/out_stall): yokoi_number with row_index and
// column_index; last_of_image marks the bottom-right pixel of the image.
// threshold_wr_en/threshold_wr_data set the binarization level; write only
// while idle.
// The item is held in the job stage, then its result in the result register.
// Throughput: one item per cycle while out_stall is low; a last-column pixel
// of any row but the first yields two results and holds the input until the
// first has gone into the single result register.
// Two pixel rows live in shift lines; no clearing pass follows reset. Reset
// returns the raster position to the first pixel, empties the pipeline and sets
// the threshold to 128. While out_stall holds a valid result, items that release
// no result still go in; one that does waits in the job stage and raises in_stall.
module yokoi_connectivity_stream_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        threshold_wr_en,
	input  logic [ycs_pkg::GRAY_W-1:0]  threshold_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [ycs_pkg::GRAY_W-1:0]  gray_pixel,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ycs_pkg::YOKOI_W-1:0] yokoi_number,
	output logic [ycs_pkg::IDX_W-1:0]   row_index,
	output logic [ycs_pkg::IDX_W-1:0]   column_index,
	output logic                        last_of_image
);
	import ycs_pkg::*;

	logic [GRAY_W-1:0] threshold_q;
	logic              in_accept;
	job_t              job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (threshold_wr_en) begin
			threshold_q <= threshold_wr_data;
		end
	end

	assign in_accept = in_valid && !in_stall;

	ycs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.kind       (kind),
		.gray_pixel (gray_pixel),
		.threshold  (threshold_q),
		.job        (job)
	);

	ycs_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_accept     (in_accept),
		.job           (job),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.yokoi_number  (yokoi_number),
		.row_index     (row_index),
		.column_index  (column_index),
		.last_of_image (last_of_image)
	);

`include "yokoi_connectivity_stream_core_assert.svh"

	`YCS_ASSERT_NOW(a_code_range, out_valid, yokoi_number <= INTERIOR_CODE)
	`YCS_ASSERT_NOW(a_last_corner, out_valid && last_of_image,
		row_index == IDX_W'(LAST_ROW) && column_index == IDX_W'(LAST_COL))
	`YCS_ASSERT_NEXT(a_stall_progress, in_stall && !out_valid, out_valid)

endmodule

FILE: tb/yokoi_number_checker.sv
module yokoi_number_checker
	import ycs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               threshold_wr_en,
	input  logic [GRAY_W-1:0]  threshold_wr_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [GRAY_W-1:0]  gray_pixel,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [YOKOI_W-1:0] yokoi_number,
	input  logic [IDX_W-1:0]   row_index,
	input  logic [IDX_W-1:0]   column_index,
	input  logic               last_of_image,
	output int                 error_count,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [YOKOI_W-1:0] yokoi;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic               last;
	} yokoi_entry_t;

	yokoi_entry_t      pending_yokoi[$];
	bit                binary_rows [3][IMAGE_WIDTH];
	int                raster_row;
	int                raster_col;
	int                drain_col;
	logic [GRAY_W-1:0] level;

	function automatic bit fg_at(int r, int c);
		if (r < 0 || r >= IMAGE_HEIGHT || c < 0 || c >= IMAGE_WIDTH)
			return 1'b0;
		return binary_rows[r % 3][c];
	endfunction

	function automatic logic [YOKOI_W-1:0] yokoi_of(int r, int c);
		bit a [4];
		bit d [4];
		bit e [4];
		int q;
		int full;
		int k;
		if (!fg_at(r, c))
			return '0;
		a[0] = fg_at(r, c + 1);     d[0] = fg_at(r - 1, c + 1); e[0] = fg_at(r - 1, c);
		a[1] = fg_at(r - 1, c);     d[1] = fg_at(r - 1, c - 1); e[1] = fg_at(r, c - 1);
		a[2] = fg_at(r, c - 1);     d[2] = fg_at(r + 1, c - 1); e[2] = fg_at(r + 1, c);
		a[3] = fg_at(r + 1, c);     d[3] = fg_at(r + 1, c + 1); e[3] = fg_at(r, c + 1);
		q = 0;
		full = 0;
		for (k = 0; k < 4; k++) begin
			if (a[k]) begin
				if (d[k] && e[k])
					full++;
				else
					q++;
			end
		end
		if (full == 4)
			return INTERIOR_CODE;
		return YOKOI_W'(q);
	endfunction

	task automatic push_yokoi(int r, int c, logic last);
		yokoi_entry_t ent;
		ent.yokoi = yokoi_of(r, c);
		ent.row = IDX_W'(r);
		ent.col = IDX_W'(c);
		ent.last = last;
		pending_yokoi.push_back(ent);
	endtask

	task automatic advance_raster(logic k, logic [GRAY_W-1:0] g);
		logic last;
		if (k == KIND_PIXEL) begin
			if (raster_row < IMAGE_HEIGHT) begin
				binary_rows[raster_row % 3][raster_col] = (g >= level);
				if (raster_row >= 1 && raster_col >= 1)
					push_yokoi(raster_row - 1, raster_col - 1, 1'b0);
				if (raster_row >= 1 && raster_col == IMAGE_WIDTH - 1)
					push_yokoi(raster_row - 1, raster_col, 1'b0);
				raster_col++;
				if (raster_col >= IMAGE_WIDTH) begin
					raster_col = 0;
					raster_row++;
				end
			end
		end else if (raster_row >= IMAGE_HEIGHT && drain_col < IMAGE_WIDTH) begin
			last = (drain_col == IMAGE_WIDTH - 1);
			push_yokoi(IMAGE_HEIGHT - 1, drain_col, last);
			drain_col++;
			if (last) begin
				raster_row = 0;
				raster_col = 0;
				drain_col = 0;
			end
		end
	endtask

	task automatic check_result();
		yokoi_entry_t ent;
		if (pending_yokoi.size() == 0) begin
			$error("unexpected result: yokoi_number %0d row_index %0d column_index %0d",
				yokoi_number, row_index, column_index);
			error_count++;
		end else begin
			ent = pending_yokoi.pop_front();
			if (yokoi_number !== ent.yokoi) begin
				$error("yokoi_number: expected %0d, actual %0d", ent.yokoi, yokoi_number);
				error_count++;
			end
			if (row_index !== ent.row) begin
				$error("row_index: expected %0d, actual %0d", ent.row, row_index);
				error_count++;
			end
			if (column_index !== ent.col) begin
				$error("column_index: expected %0d, actual %0d", ent.col, column_index);
				error_count++;
			end
			if (last_of_image !== ent.last) begin
				$error("last_of_image: expected %0d, actual %0d", ent.last, last_of_image);
				error_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_yokoi.delete();
			foreach (binary_rows[i, j])
				binary_rows[i][j] = 1'b0;
			raster_row = 0;
			raster_col = 0;
			drain_col = 0;
			level = THRESHOLD_RESET;
			error_count = 0;
			outstanding = 0;
		end else begin
			if (threshold_wr_en)
				level = threshold_wr_data;
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				advance_raster(kind, gray_pixel);
			outstanding = pending_yokoi.size();
		end
	end

endmodule

FILE: tb/yokoi_connectivity_stream_core_test.sv
module yokoi_connectivity_stream_core_test import ycs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF       = 400;
	localparam int PRESSURE_AT    = 300;
	localparam int PHASE_ROWS     = 5;
	localparam int ROWS_SENT      = 30;

	logic               clk;
	logic               arst_n            = 1'b0;
	logic               threshold_wr_en   = 1'b0;
	logic [GRAY_W-1:0]  threshold_wr_data = '0;
	logic               in_valid          = 1'b0;
	logic               in_stall;
	logic               kind              = KIND_PIXEL;
	logic [GRAY_W-1:0]  gray_pixel        = '0;
	logic               out_valid;
	logic               out_stall         = 1'b0;
	logic [YOKOI_W-1:0] yokoi_number;
	logic [IDX_W-1:0]   row_index;
	logic [IDX_W-1:0]   column_index;
	logic               last_of_image;

	int                 mismatches;
	int                 outstanding;
	bit                 sender_quiet      = 1'b0;
	logic [GRAY_W-1:0]  level             = THRESHOLD_RESET;
	logic [GRAY_W-1:0]  boundary_grays [6] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254};

	yokoi_connectivity_stream_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.threshold_wr_en  (threshold_wr_en),
		.threshold_wr_data(threshold_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.gray_pixel       (gray_pixel),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.yokoi_number     (yokoi_number),
		.row_index        (row_index),
		.column_index     (column_index),
		.last_of_image    (last_of_image)
	);

	yokoi_number_checker yokoi_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.threshold_wr_en  (threshold_wr_en),
		.threshold_wr_data(threshold_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.gray_pixel       (gray_pixel),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.yokoi_number     (yokoi_number),
		.row_index        (row_index),
		.column_index     (column_index),
		.last_of_image    (last_of_image),
		.error_count      (mismatches),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic send_item(logic k, logic [GRAY_W-1:0] g);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		gray_pixel <= g;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_level(logic [GRAY_W-1:0] v);
		threshold_wr_en <= 1'b1;
		threshold_wr_data <= v;
		level = v;
		@(posedge clk);
		threshold_wr_en <= 1'b0;
	endtask

	function automatic logic [GRAY_W-1:0] gray_for(bit fg);
		if (fg || level == 0)
			return GRAY_W'($urandom_range(int'(level), 255));
		return GRAY_W'($urandom_range(0, int'(level) - 1));
	endfunction

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int hold;
		int taken;
		bit quiet;
		taken = 0;
		quiet = 1'b0;
		forever begin
			if (taken % 97 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (taken == PRESSURE_AT)
				hold = HOLD_OFF;
			else
				hold = quiet ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			taken++;
		end
	end

	initial begin
		int row;
		int col;
		int phase;
		int style;
		int density;
		logic [GRAY_W-1:0] g;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// drain before any pixel: dropped by the block
		send_item(KIND_DRAIN, 8'hFF);
		phase = 0;
		for (row = 0; row < ROWS_SENT; row++) begin
			if (row % PHASE_ROWS == 0 && row != 0) begin
				phase++;
				settle();
				case (phase)
					1:       write_level(8'd0);
					2, 5:    write_level(8'd255);
					4:       write_level(THRESHOLD_RESET);
					default: write_level(GRAY_W'($urandom_range(1, 254)));
				endcase
			end
			sender_quiet = ($urandom_range(0, 4) == 0);
			style = $urandom_range(0, 3);
			density = $urandom_range(0, 8);
			for (col = 0; col < IMAGE_WIDTH; col++) begin
				case (style)
					0:       g = GRAY_W'($urandom_range(0, 255));
					3:       g = gray_for((col / 4) % 2 == 1);
					default: g = gray_for($urandom_range(1, 8) <= density);
				endcase
				if (row == 0 && col < 6)
					g = boundary_grays[col];
				// drain while the image is still arriving: dropped
				if ($urandom_range(0, 63) == 0)
					send_item(KIND_DRAIN, GRAY_W'($urandom));
				send_item(KIND_PIXEL, g);
			end
		end
		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: yokoi_connectivity_stream_core.f
+incdir+sv
sv/ycs_pkg.sv
sv/ycs_front.sv
sv/ycs_emit.sv
sv/yokoi_connectivity_stream_core.sv
tb/yokoi_number_checker.sv
tb/yokoi_connectivity_stream_core_test.sv
